### sv/psc_pkg.sv
package psc_pkg;

    localparam logic [7:0] CH_STRESS = 8'h27;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    localparam int IDX_W      = 5;
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = 2;
    localparam int CNT_W      = 3;

    // symbol indexes: single-character symbols first, then the pairs
    localparam logic [IDX_W-1:0] IDX_T  = 5'd2;
    localparam logic [IDX_W-1:0] IDX_D  = 5'd3;
    localparam logic [IDX_W-1:0] IDX_R  = 5'd21;
    localparam logic [IDX_W-1:0] IDX_J  = 5'd23;
    localparam logic [IDX_W-1:0] IDX_TS = 5'd28;
    localparam logic [IDX_W-1:0] IDX_JJ = 5'd29;
    localparam logic [IDX_W-1:0] IDX_RR = 5'd30;
    localparam logic [IDX_W-1:0] IDX_DZ = 5'd31;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] idx;
    } psc_hit_t;

    typedef struct packed {
        logic [IDX_W-1:0] a_idx;
        logic             a_st;
        logic             b_vld;
        logic [IDX_W-1:0] b_idx;
        logic             b_st;
        logic             wend;
    } psc_cmd_t;

    function automatic psc_hit_t mono_lookup(input logic [7:0] c);
        psc_hit_t h;
        h.found = 1'b1;
        h.idx   = '0;
        case (c)
            "p": h.idx = 5'd0;
            "b": h.idx = 5'd1;
            "t": h.idx = IDX_T;
            "d": h.idx = IDX_D;
            "k": h.idx = 5'd4;
            "g": h.idx = 5'd5;
            "m": h.idx = 5'd6;
            "n": h.idx = 5'd7;
            "J": h.idx = 5'd8;
            "N": h.idx = 5'd9;
            "B": h.idx = 5'd10;
            "f": h.idx = 5'd11;
            "T": h.idx = 5'd12;
            "D": h.idx = 5'd13;
            "s": h.idx = 5'd14;
            "z": h.idx = 5'd15;
            "x": h.idx = 5'd16;
            "G": h.idx = 5'd17;
            "l": h.idx = 5'd18;
            "L": h.idx = 5'd19;
            "e": h.idx = 5'd20;
            "r": h.idx = IDX_R;
            "i": h.idx = 5'd22;
            "j": h.idx = IDX_J;
            "a": h.idx = 5'd24;
            "o": h.idx = 5'd25;
            "u": h.idx = 5'd26;
            "w": h.idx = 5'd27;
            default: h.found = 1'b0;
        endcase
        return h;
    endfunction

    function automatic psc_hit_t duo_lookup(input logic [7:0] a, input logic [7:0] b);
        psc_hit_t h;
        h.found = 1'b1;
        h.idx   = '0;
        if (a == "t" && b == "S") begin
            h.idx = IDX_TS;
        end else if (a == "j" && b == "j") begin
            h.idx = IDX_JJ;
        end else if (a == "r" && b == "r") begin
            h.idx = IDX_RR;
        end else if (a == "d" && b == "Z") begin
            h.idx = IDX_DZ;
        end else begin
            h.found = 1'b0;
        end
        return h;
    endfunction

    function automatic logic is_lead(input logic [7:0] c);
        return (c == "t") || (c == "j") || (c == "r") || (c == "d");
    endfunction

    function automatic logic [1:0] name_len(input logic [IDX_W-1:0] idx);
        logic [1:0] n;
        case (idx)
            5'd8:  n = 2'd3;
            5'd9, 5'd12, 5'd13, 5'd19, 5'd20, 5'd21, 5'd22, 5'd24, 5'd25, 5'd26,
            IDX_TS, IDX_DZ: n = 2'd2;
            5'd10, 5'd16, 5'd17, IDX_JJ: n = 2'd0;
            default: n = 2'd1;
        endcase
        return n;
    endfunction

    // characters of a name, first character in the low byte
    function automatic logic [23:0] name_str(input logic [IDX_W-1:0] idx);
        logic [23:0] s;
        case (idx)
            5'd0:   s = {8'h00, 8'h00, "p"};
            5'd1:   s = {8'h00, 8'h00, "b"};
            IDX_T:  s = {8'h00, 8'h00, "t"};
            IDX_D:  s = {8'h00, 8'h00, "d"};
            5'd4:   s = {8'h00, 8'h00, "k"};
            5'd5:   s = {8'h00, 8'h00, "g"};
            5'd6:   s = {8'h00, 8'h00, "m"};
            5'd7:   s = {8'h00, 8'h00, "n"};
            5'd8:   s = {"g", "n", "e"};
            5'd9:   s = {8'h00, "g", "n"};
            5'd11:  s = {8'h00, 8'h00, "f"};
            5'd12:  s = {8'h00, "h", "t"};
            5'd13:  s = {8'h00, "h", "d"};
            5'd14:  s = {8'h00, 8'h00, "s"};
            5'd15:  s = {8'h00, 8'h00, "z"};
            5'd18:  s = {8'h00, 8'h00, "l"};
            5'd19:  s = {8'h00, "l", "e"};
            5'd20:  s = {8'h00, "h", "e"};
            IDX_R:  s = {8'h00, "x", "d"};
            5'd22:  s = {8'h00, "y", "t"};
            IDX_J:  s = {8'h00, 8'h00, "y"};
            5'd24:  s = {8'h00, "a", "a"};
            5'd25:  s = {8'h00, "o", "a"};
            5'd26:  s = {8'h00, "w", "u"};
            5'd27:  s = {8'h00, 8'h00, "w"};
            IDX_TS: s = {8'h00, "h", "c"};
            IDX_RR: s = {8'h00, 8'h00, "r"};
            IDX_DZ: s = {8'h00, "h", "j"};
            default: s = '0;
        endcase
        return s;
    endfunction

endpackage

### sv/psc_front.sv
module psc_front
    import psc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    input  logic        fifo_full,
    output logic        push,
    output psc_cmd_t    push_data
);

    logic       held_valid_reg, held_valid_next;
    logic [7:0] held_char_reg, held_char_next;
    logic       held_stress_reg, held_stress_next;
    logic       stress_reg, stress_next;

    logic       accept;
    psc_hit_t   duo_hit, held_hit, cur_hit;
    logic       consumed, hold_cur, job_a, job_b;
    logic [IDX_W-1:0] a_idx;

    assign s_tready = !fifo_full;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        duo_hit  = duo_lookup(held_char_reg, s_tdata);
        held_hit = mono_lookup(held_char_reg);
        cur_hit  = mono_lookup(s_tdata);
        consumed = held_valid_reg && duo_hit.found;
        hold_cur = !consumed && s_tdata != CH_STRESS && is_lead(s_tdata) && !s_tlast;
        job_a    = held_valid_reg && (duo_hit.found || held_hit.found);
        a_idx    = duo_hit.found ? duo_hit.idx : held_hit.idx;
        job_b    = !consumed && s_tdata != CH_STRESS && !hold_cur && cur_hit.found;

        held_valid_next  = hold_cur;
        held_char_next   = hold_cur ? s_tdata : 8'h00;
        held_stress_next = hold_cur && stress_reg;

        stress_next = stress_reg;
        if (!consumed) begin
            if (s_tdata == CH_STRESS) begin
                stress_next = 1'b1;
            end else if (hold_cur || job_b) begin
                stress_next = 1'b0;
            end
        end
        if (s_tlast) begin
            stress_next = 1'b0;
        end

        // a lone current symbol moves into the first slot
        push_data.wend = s_tlast;
        if (job_a) begin
            push_data.a_idx = a_idx;
            push_data.a_st  = held_stress_reg;
            push_data.b_vld = job_b;
        end else begin
            push_data.a_idx = cur_hit.idx;
            push_data.a_st  = stress_reg;
            push_data.b_vld = 1'b0;
        end
        push_data.b_idx = cur_hit.idx;
        push_data.b_st  = stress_reg;

        push = accept && (job_a || job_b);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_valid_reg  <= 1'b0;
            held_char_reg   <= 8'h00;
            held_stress_reg <= 1'b0;
            stress_reg      <= 1'b0;
        end else if (accept) begin
            held_valid_reg  <= held_valid_next;
            held_char_reg   <= held_char_next;
            held_stress_reg <= held_stress_next;
            stress_reg      <= stress_next;
        end
    end

endmodule

### sv/psc_fifo.sv
module psc_fifo
    import psc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  psc_cmd_t push_data,
    output logic     full,
    input  logic     pop,
    output psc_cmd_t pop_data,
    output logic     empty
);

    psc_cmd_t          mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full     = count_reg == CNT_W'(FIFO_DEPTH);
    assign empty    = count_reg == '0;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

### sv/psc_back.sv
module psc_back
    import psc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       fifo_empty,
    input  psc_cmd_t   fifo_data,
    output logic       pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast,
    output logic       m_tuser
);

    logic       cmd_valid_reg;
    psc_cmd_t   cmd_reg;
    logic       job_reg;
    logic [2:0] pos_reg;

    logic       out_valid_reg;
    logic [7:0] out_data_reg;
    logic       out_last_reg;
    logic       out_wlast_reg;

    logic [IDX_W-1:0] cur_idx;
    logic             cur_st;
    logic [2:0]       len;
    logic [23:0]      str;
    logic [7:0]       cur_byte;
    logic             is_space, fin, can_load, emit;

    always_comb begin
        cur_idx  = job_reg ? cmd_reg.b_idx : cmd_reg.a_idx;
        cur_st   = job_reg ? cmd_reg.b_st : cmd_reg.a_st;
        len      = {1'b0, name_len(cur_idx)};
        str      = name_str(cur_idx);
        is_space = 1'b0;
        if (pos_reg < len) begin
            cur_byte = str[pos_reg[1:0]*8 +: 8];
        end else if (pos_reg == len && cur_st) begin
            cur_byte = CH_ONE;
        end else begin
            cur_byte = CH_SPACE;
            is_space = 1'b1;
        end
        fin      = is_space && (job_reg || !cmd_reg.b_vld);
        can_load = !out_valid_reg || m_tready;
        emit     = cmd_valid_reg && can_load;
        pop      = !fifo_empty && (!cmd_valid_reg || (emit && fin));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_valid_reg <= 1'b0;
            job_reg       <= 1'b0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                cmd_valid_reg <= 1'b1;
                job_reg       <= 1'b0;
                pos_reg       <= '0;
            end else if (emit) begin
                if (fin) begin
                    cmd_valid_reg <= 1'b0;
                end
                if (is_space) begin
                    job_reg <= 1'b1;
                    pos_reg <= '0;
                end else begin
                    pos_reg <= pos_reg + 1'b1;
                end
            end
            if (can_load) begin
                out_valid_reg <= emit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            cmd_reg <= fifo_data;
        end
        if (emit) begin
            out_data_reg  <= cur_byte;
            out_last_reg  <= fin;
            out_wlast_reg <= fin && cmd_reg.wend;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_wlast_reg;

endmodule

### sv/phoneme_symbol_converter.sv
// the first output byte of a request passes a queue entry, the command register and the output register;
// a held t, j, r or d waits for the next request before it is decided
// throughput: one output byte per cycle from the back end while m_tready is high; a request yields
// zero to nine bytes, a four-entry queue lets the front run ahead
// the front accepts one request per cycle while the queue has room
// reset: synchronous active-low aresetn clears lookahead, stress, queue and output
module phoneme_symbol_converter
    import psc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // in_byte
    input  logic       s_tlast,   // word_end
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte
    output logic       m_tlast,   // run_last
    output logic       m_tuser    // word_last
);

    logic     fifo_full, fifo_empty, push, pop;
    psc_cmd_t push_data, pop_data;

    psc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .fifo_full (fifo_full),
        .push      (push),
        .push_data (push_data)
    );

    psc_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (fifo_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (fifo_empty)
    );

    psc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fifo_empty (fifo_empty),
        .fifo_data  (pop_data),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule
